>>> hdl/pct_pkg.sv
// ----------------------------------------------------------------------------
// pct_pkg: shared types and constants of the peer cooldown table
// Table depth, field widths, operation codes and controller/datapath bundles.
// ----------------------------------------------------------------------------
package pct_pkg;

  // table depth and scan index width
  localparam int unsigned ENTRIES = 8;
  localparam int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // field widths
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned ADDR_W   = 48;
  localparam int unsigned ATYPE_W  = 2;
  localparam int unsigned TIME_W   = 48;
  localparam int unsigned KEY_W    = ADDR_W + ATYPE_W;
  localparam int unsigned DL_W     = 49;
  localparam int unsigned SECS_W   = 16;
  localparam int unsigned PROD_W   = 26;
  localparam int unsigned REMAIN_W = 26;

  // stream word widths
  localparam int unsigned IN_BITS  = KIND_W + ADDR_W + ATYPE_W + TIME_W;
  localparam int unsigned IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_BITS = 1 + REMAIN_W;
  localparam int unsigned OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  // constants
  localparam logic [SECS_W-1:0]   SECS_RESET = 16'd60;
  localparam logic [9:0]          MS_PER_S   = 10'd1000;
  localparam logic [REMAIN_W-1:0] REMAIN_MAX = 26'd65535000;

  // operation codes
  localparam logic [KIND_W-1:0] KIND_CHECK = 2'd0;
  localparam logic [KIND_W-1:0] KIND_START = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic             load;
    logic             scan;
    logic             first;
    logic             update;
    logic             out_load;
    logic [IDX_W-1:0] idx;
  } pct_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_busy;
  } pct_sts_t;

endpackage

>>> hdl/peer_cooldown_table_top.sv
// A word is latched on acceptance; the table is then scanned one entry per cycle,
// followed by the update and output steps, before the next word is accepted. A word
// is taken while a result waits, but its output step holds until the waiting result
// is taken.
// Reset (rst_ni low, asynchronous): all entries cleared to address zero and free,
// cooldown_seconds back to 60, no result pending.
// ----------------------------------------------------------------------------
// peer_cooldown_table_top: peer cooldown table
// Looks up, starts and clears per-peer cooldown deadlines in a small table.
// ----------------------------------------------------------------------------
module peer_cooldown_table_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [pct_pkg::SECS_W-1:0] cfg_wdata_i,     // cooldown_seconds
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // kind[1:0], peer_address[49:2], address_type[51:50], now_ms[99:52], zero pad
  input  logic [pct_pkg::IN_W-1:0]   s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // in_cooldown[0], wait_ms[26:1], zero pad
  output logic [pct_pkg::OUT_W-1:0]  m_axis_tdata
);
  import pct_pkg::*;

  pct_cmd_t cmd;
  pct_sts_t sts;

  pct_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  pct_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cmd_i         (cmd),
    .sts_o         (sts)
  );

endmodule

>>> hdl/pct_ctrl.sv
// ----------------------------------------------------------------------------
// pct_ctrl: sequencer of the peer cooldown table
// Walks the table one entry per cycle, then issues the update and output steps.
// ----------------------------------------------------------------------------
module pct_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  pct_pkg::pct_sts_t sts_i,
  output pct_pkg::pct_cmd_t cmd_o
);
  import pct_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_UPDATE = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             last_idx;

  assign last_idx      = (idx_q == IDX_W'(ENTRIES - 1));
  assign s_axis_tready = (state_q == ST_IDLE);

  // next state and commands
  always_comb begin
    state_d          = state_q;
    idx_d            = idx_q;
    cmd_o            = '0;
    cmd_o.idx        = idx_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_o.load = 1'b1;
          idx_d      = '0;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan  = 1'b1;
        cmd_o.first = (idx_q == '0);
        if (last_idx) begin
          state_d = ST_UPDATE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = ST_FINISH;
      end
      ST_FINISH: begin
        // hold until the output register is free
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

endmodule

>>> hdl/pct_dp.sv
// ----------------------------------------------------------------------------
// pct_dp: datapath of the peer cooldown table
// Holds the table, the scan results, the deadline arithmetic and the result word.
// ----------------------------------------------------------------------------
module pct_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [pct_pkg::SECS_W-1:0] cfg_wdata_i,
  input  logic [pct_pkg::IN_W-1:0]   s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [pct_pkg::OUT_W-1:0]  m_axis_tdata,
  input  pct_pkg::pct_cmd_t          cmd_i,
  output pct_pkg::pct_sts_t          sts_o
);
  import pct_pkg::*;

  // table storage
  logic [KEY_W-1:0] addr_q [ENTRIES];
  logic [DL_W-1:0]  dl_q   [ENTRIES];

  logic [SECS_W-1:0] secs_q;

  // latched item
  logic [KIND_W-1:0] kind_q;
  logic [KEY_W-1:0]  key_q;
  logic [TIME_W-1:0] now_q;
  logic [PROD_W-1:0] prod_q;

  // scan results
  logic             found_q, free_found_q;
  logic [IDX_W-1:0] match_idx_q, free_idx_q, old_idx_q;
  logic [DL_W-1:0]  match_dl_q, old_dl_q;

  // update results
  logic             cool_q;
  logic [DL_W-1:0]  diff_q;

  // output register
  logic                tvalid_q;
  logic                res_cool_q;
  logic [REMAIN_W-1:0] res_remain_q;

  logic [KEY_W-1:0] rd_addr;
  logic [DL_W-1:0]  rd_dl;
  logic             hit, is_free;
  logic             expired;
  logic [DL_W-1:0]  diff;
  logic [DL_W-1:0]  start_dl;
  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  logic             wr_key;
  logic [DL_W-1:0]  wr_dl;

  assign rd_addr = addr_q[cmd_i.idx];
  assign rd_dl   = dl_q[cmd_i.idx];
  assign hit     = (rd_addr == key_q);
  assign is_free = (rd_dl == '0);

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      secs_q <= SECS_RESET;
    end else if (cfg_we_i) begin
      secs_q <= cfg_wdata_i;
    end
  end

  // latch the word and the cooldown length in ms
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= s_axis_tdata[KIND_W-1:0];
      key_q  <= {s_axis_tdata[KIND_W+ADDR_W +: ATYPE_W], s_axis_tdata[KIND_W +: ADDR_W]};
      now_q  <= s_axis_tdata[KIND_W+ADDR_W+ATYPE_W +: TIME_W];
      prod_q <= PROD_W'(secs_q * MS_PER_S);
    end
  end

  // track first match, first free entry and smallest deadline
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan) begin
      if (cmd_i.first) begin
        found_q      <= hit;
        match_idx_q  <= cmd_i.idx;
        match_dl_q   <= rd_dl;
        free_found_q <= is_free;
        free_idx_q   <= cmd_i.idx;
        old_idx_q    <= cmd_i.idx;
        old_dl_q     <= rd_dl;
      end else begin
        if (!found_q && hit) begin
          found_q     <= 1'b1;
          match_idx_q <= cmd_i.idx;
          match_dl_q  <= rd_dl;
        end
        if (!free_found_q && is_free) begin
          free_found_q <= 1'b1;
          free_idx_q   <= cmd_i.idx;
        end
        if (rd_dl < old_dl_q) begin
          old_idx_q <= cmd_i.idx;
          old_dl_q  <= rd_dl;
        end
      end
    end
  end

  // deadline arithmetic
  assign expired  = (match_dl_q <= {1'b0, now_q});
  assign diff     = match_dl_q - {1'b0, now_q};
  assign start_dl = {1'b0, now_q} + {{(DL_W-PROD_W){1'b0}}, prod_q};

  // choose the table write of the update step
  always_comb begin
    wr_en  = 1'b0;
    wr_key = 1'b0;
    wr_idx = match_idx_q;
    wr_dl  = '0;
    case (kind_q)
      KIND_CHECK: wr_en = found_q && expired;
      KIND_START: begin
        wr_en  = 1'b1;
        wr_key = 1'b1;
        wr_dl  = start_dl;
        if (!found_q) begin
          wr_idx = free_found_q ? free_idx_q : old_idx_q;
        end
      end
      KIND_CLEAR: wr_en = found_q;
      default:    wr_en = 1'b0;
    endcase
  end

  // table write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) begin
        addr_q[i] <= '0;
        dl_q[i]   <= '0;
      end
    end else if (cmd_i.update && wr_en) begin
      dl_q[wr_idx] <= wr_dl;
      if (wr_key) begin
        addr_q[wr_idx] <= key_q;
      end
    end
  end

  // register the check outcome
  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      cool_q <= (kind_q == KIND_CHECK) && found_q && !expired;
      diff_q <= diff;
    end
  end

  // output register: saturate the remaining time
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tvalid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      tvalid_q <= 1'b1;
    end else if (m_axis_tready) begin
      tvalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      res_cool_q <= cool_q;
      if (!cool_q) begin
        res_remain_q <= '0;
      end else if (diff_q > {{(DL_W-REMAIN_W){1'b0}}, REMAIN_MAX}) begin
        res_remain_q <= REMAIN_MAX;
      end else begin
        res_remain_q <= diff_q[REMAIN_W-1:0];
      end
    end
  end

  assign m_axis_tvalid  = tvalid_q;
  assign m_axis_tdata   = {{(OUT_W-OUT_BITS){1'b0}}, res_remain_q, res_cool_q};
  assign sts_o.out_busy = tvalid_q && !m_axis_tready;

endmodule
